// ===== rtl/core/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants of the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int INT_W   = 64;
  localparam int INDEX_W = 3;

  typedef enum logic [INDEX_W-1:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_LO  = 3'd3,
    REG_HI  = 3'd4,
    REG_DT  = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_LOAD     = 4'd1,
    CMD_CLEAR    = 4'd2,
    CMD_MUL_STEP = 4'd3,
    CMD_INTEG    = 4'd4,
    CMD_LOAD_KI  = 4'd5,
    CMD_DIV_INIT = 4'd6,
    CMD_DIV_STEP = 4'd7,
    CMD_LOAD_KD  = 4'd8,
    CMD_FINISH   = 4'd9
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic dt_zero;
  } dp_status_t;

endpackage

// ===== rtl/core/pca_datapath.sv =====
// ----------------------------------------------------------------------------
// pca_datapath
// Registers, shift-add multiplier and restoring divider of the PID step.
// ----------------------------------------------------------------------------
module pca_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int GAIN_WIDTH = 36,
  parameter int CFG_W      = 36
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pca_pkg::ctrl_cmd_t               cmd,
  output pca_pkg::dp_status_t              status,
  input  logic                             cfg_we,
  input  logic [pca_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data,
  input  logic signed [DATA_WIDTH-1:0]     setpoint,
  input  logic signed [DATA_WIDTH-1:0]     measured,
  input  logic [DATA_WIDTH-1:0]            time_step,
  output logic [DATA_WIDTH-1:0]            control_out,
  output logic                             saturated
);

  localparam int DW     = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int GW     = GAIN_WIDTH;
  localparam int INT_W  = pca_pkg::INT_W;
  localparam int E_W    = DW + 1;
  localparam int D_W    = DW + 2;
  localparam int NUM_W  = D_W + FB;
  localparam int B_W    = (GW > DW) ? GW : DW;
  localparam int P1     = 2 * DW + 2;
  localparam int P2     = INT_W + GW + 1;
  localparam int ACC_W  = ((P1 > P2) ? P1 : P2) + 2;
  localparam int MAXN   = (NUM_W > B_W) ? NUM_W : B_W;
  localparam int CNT_W  = $clog2(MAXN);
  localparam int QX_W   = NUM_W + INT_W;
  localparam int DT_DEF = ((1 << FB) + 5) / 10;

  logic [GW-1:0]           kp, ki, kd;
  logic signed [DW-1:0]    lo, hi;
  logic [DW-1:0]           ddt;

  logic signed [E_W-1:0]   e_r, prev;
  logic [DW-1:0]           dt_r;
  logic signed [INT_W-1:0] integ, old_integ;
  logic signed [ACC_W-1:0] acc, mcand;
  logic [B_W-1:0]          mplier;
  logic [CNT_W-1:0]        cnt;
  logic [DW-1:0]           rem;
  logic [NUM_W-1:0]        nq;
  logic                    neg;
  logic [DW-1:0]           out_r;
  logic                    sat_r;

  logic signed [E_W-1:0]   e_in;
  logic [DW-1:0]           dt_in;
  logic signed [ACC_W-1:0] acc_step, inc, old_ext, sum, full, lo_ext, hi_ext;
  logic signed [ACC_W-1:0] max_ext, min_ext;
  logic signed [INT_W-1:0] integ_sat, rate;
  logic signed [D_W-1:0]   diff;
  logic [D_W-1:0]          diff_mag;
  logic [DW:0]             r2;
  logic                    ge;
  logic [QX_W-1:0]         qx;
  logic [INT_W-1:0]        rate_mag;
  logic                    clamp_lo, clamp_hi;

  always_comb begin
    e_in     = $signed({setpoint[DW-1], setpoint}) - $signed({measured[DW-1], measured});
    dt_in    = (time_step == '0) ? ddt : time_step;
    acc_step = mplier[0] ? acc + mcand : acc;
    inc      = acc >>> FB;
    old_ext  = ACC_W'(integ);
    sum      = old_ext + inc;
    max_ext  = ACC_W'({1'b0, {(INT_W-1){1'b1}}});
    min_ext  = -max_ext - ACC_W'(1);
    if (sum > max_ext) begin
      integ_sat = {1'b0, {(INT_W-1){1'b1}}};
    end else if (sum < min_ext) begin
      integ_sat = {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      integ_sat = sum[INT_W-1:0];
    end
    diff     = D_W'(e_r) - D_W'(prev);
    diff_mag = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
    r2       = {rem, nq[NUM_W-1]};
    ge       = r2 >= {1'b0, dt_r};
    qx       = QX_W'(nq);
    rate_mag = (|qx[QX_W-1:INT_W-1]) ? {1'b0, {(INT_W-1){1'b1}}} : qx[INT_W-1:0];
    rate     = neg ? -$signed(rate_mag) : $signed(rate_mag);
    full     = acc >>> FB;
    lo_ext   = ACC_W'(lo);
    hi_ext   = ACC_W'(hi);
    clamp_lo = full < lo_ext;
    clamp_hi = full > hi_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp  <= '0;
      ki  <= '0;
      kd  <= '0;
      lo  <= {1'b1, {(DW-1){1'b0}}};
      hi  <= {1'b0, {(DW-1){1'b1}}};
      ddt <= DW'(DT_DEF);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pca_pkg::REG_KP: kp  <= cfg_data[GW-1:0];
        pca_pkg::REG_KI: ki  <= cfg_data[GW-1:0];
        pca_pkg::REG_KD: kd  <= cfg_data[GW-1:0];
        pca_pkg::REG_LO: lo  <= cfg_data[DW-1:0];
        pca_pkg::REG_HI: hi  <= cfg_data[DW-1:0];
        pca_pkg::REG_DT: ddt <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      prev  <= '0;
    end else begin
      unique case (cmd.op)
        pca_pkg::CMD_CLEAR: begin
          integ <= '0;
          prev  <= '0;
          out_r <= '0;
          sat_r <= 1'b0;
        end
        pca_pkg::CMD_LOAD: begin
          e_r    <= e_in;
          dt_r   <= dt_in;
          acc    <= '0;
          mcand  <= ACC_W'(e_in);
          mplier <= B_W'(dt_in);
          cnt    <= CNT_W'(DW - 1);
        end
        pca_pkg::CMD_MUL_STEP: begin
          acc    <= acc_step;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
        end
        pca_pkg::CMD_INTEG: begin
          old_integ <= integ;
          integ     <= integ_sat;
          acc       <= '0;
          mcand     <= ACC_W'(e_r);
          mplier    <= B_W'(kp);
          cnt       <= CNT_W'(GW - 1);
        end
        pca_pkg::CMD_LOAD_KI: begin
          mcand  <= ACC_W'(integ);
          mplier <= B_W'(ki);
          cnt    <= CNT_W'(GW - 1);
        end
        pca_pkg::CMD_DIV_INIT: begin
          nq  <= {diff_mag, {FB{1'b0}}};
          rem <= '0;
          neg <= diff[D_W-1];
          cnt <= CNT_W'(NUM_W - 1);
        end
        pca_pkg::CMD_DIV_STEP: begin
          rem <= ge ? DW'(r2 - {1'b0, dt_r}) : r2[DW-1:0];
          nq  <= {nq[NUM_W-2:0], ge};
          cnt <= cnt - 1'b1;
        end
        pca_pkg::CMD_LOAD_KD: begin
          mcand  <= ACC_W'(rate);
          mplier <= B_W'(kd);
          cnt    <= CNT_W'(GW - 1);
        end
        pca_pkg::CMD_FINISH: begin
          prev <= e_r;
          if (clamp_lo) begin
            out_r <= lo;
            sat_r <= 1'b1;
          end else if (clamp_hi) begin
            out_r <= hi;
            sat_r <= 1'b1;
          end else begin
            out_r <= full[DW-1:0];
            sat_r <= 1'b0;
          end
          if ((clamp_lo || clamp_hi) && (ki != '0)) begin
            integ <= old_integ;
          end
        end
        default: ;
      endcase
    end
  end

  assign status.last    = (cnt == '0);
  assign status.dt_zero = (dt_r == '0);
  assign control_out    = out_r;
  assign saturated      = sat_r;

endmodule

// ===== rtl/core/pca_ctrl.sv =====
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer of the PID step: multiply, integrate, divide, clamp, deliver.
// ----------------------------------------------------------------------------
module pca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_clear,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pca_pkg::dp_status_t status,
  output pca_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_MUL_DT   = 12'b000000000010,
    S_INTEG    = 12'b000000000100,
    S_MUL_KP   = 12'b000000001000,
    S_LOAD_KI  = 12'b000000010000,
    S_MUL_KI   = 12'b000000100000,
    S_DIV_INIT = 12'b000001000000,
    S_DIV      = 12'b000010000000,
    S_LOAD_KD  = 12'b000100000000,
    S_MUL_KD   = 12'b001000000000,
    S_FINISH   = 12'b010000000000,
    S_OUT      = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = pca_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = in_clear ? pca_pkg::CMD_CLEAR : pca_pkg::CMD_LOAD;
          state_next = in_clear ? S_OUT : S_MUL_DT;
        end
      end
      S_MUL_DT: begin
        cmd.op = pca_pkg::CMD_MUL_STEP;
        if (status.last) state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.op     = pca_pkg::CMD_INTEG;
        state_next = S_MUL_KP;
      end
      S_MUL_KP: begin
        cmd.op = pca_pkg::CMD_MUL_STEP;
        if (status.last) state_next = S_LOAD_KI;
      end
      S_LOAD_KI: begin
        cmd.op     = pca_pkg::CMD_LOAD_KI;
        state_next = S_MUL_KI;
      end
      S_MUL_KI: begin
        cmd.op = pca_pkg::CMD_MUL_STEP;
        if (status.last) state_next = status.dt_zero ? S_FINISH : S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = pca_pkg::CMD_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = pca_pkg::CMD_DIV_STEP;
        if (status.last) state_next = S_LOAD_KD;
      end
      S_LOAD_KD: begin
        cmd.op     = pca_pkg::CMD_LOAD_KD;
        state_next = S_MUL_KD;
      end
      S_MUL_KD: begin
        cmd.op = pca_pkg::CMD_MUL_STEP;
        if (status.last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op     = pca_pkg::CMD_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// ===== rtl/core/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point positional PID step with output clamp and integral rollback.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata setpoint,measured,time_step; tuser opcode
// m_*       out  m_tvalid/m_tready  tdata control_out; tuser saturated
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One transaction at a time. A compute transaction runs through the
// one-bit-per-cycle shift-add multiplier and the restoring divider; when both
// the time step and default_dt are zero the divide and kd product are skipped.
// A clear transaction gives its result the next cycle.
// Reset is synchronous; a held result stalls the input until taken.
module pid_controller_antiwindup #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int GAIN_WIDTH = 36
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // setpoint, measured, time_step
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // opcode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // control_out
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // saturated
  output logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic [pca_pkg::INDEX_W-1:0]     cfg_index,
  input  logic [((GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH)-1:0] cfg_data
);

  localparam int DW       = DATA_WIDTH;
  localparam int OUT_TD_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int CFG_W    = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH;

  pca_pkg::ctrl_cmd_t  cmd;
  pca_pkg::dp_status_t status;
  logic [DW-1:0]       control_out;

  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_clear  (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pca_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .GAIN_WIDTH (GAIN_WIDTH),
    .CFG_W      (CFG_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .setpoint    (s_tdata[DW-1:0]),
    .measured    (s_tdata[2*DW-1:DW]),
    .time_step   (s_tdata[3*DW-1:2*DW]),
    .control_out (control_out),
    .saturated   (m_tuser)
  );

  assign m_tdata = OUT_TD_W'(control_out);

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> m_tvalid && !m_tuser && (m_tdata == '0))
    else $error("clear transaction did not give a zero result");

  a_compute_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !m_tvalid && !s_tready)
    else $error("compute transaction finished too early");
`endif

endmodule
